@@ hw/rtl/xxh64_pkg.sv @@
// Shared constants, types and helpers for the XXH64 stream hash core.
// Used by xxh64_if.sv, xxh64_mul.sv and xxh64_stream_hash_core.sv; no dependencies.

package xxh64_pkg;

    localparam int unsigned WORD_W = 64;
    localparam int unsigned CNT_W  = 4;
    localparam int unsigned HALF_W = 32;

    localparam logic [WORD_W-1:0] PRIME64_1 = 64'h9E3779B185EBCA87;
    localparam logic [WORD_W-1:0] PRIME64_2 = 64'hC2B2AE3D27D4EB4F;
    localparam logic [WORD_W-1:0] PRIME64_3 = 64'h165667B19E3779F9;
    localparam logic [WORD_W-1:0] PRIME64_4 = 64'h85EBCA77C2B2AE63;
    localparam logic [WORD_W-1:0] PRIME64_5 = 64'h27D4EB2F165667C5;

    localparam logic [CNT_W-1:0]  WORD_BYTES      = 4'd8;
    localparam logic [CNT_W-1:0]  HALF_WORD_BYTES = 4'd4;
    localparam logic [2:0]        POS_AFTER_HALF  = 3'd4;
    localparam logic [WORD_W-1:0] WORD_BYTES_64   = 64'd8;
    localparam logic [1:0]        LAST_LANE       = 2'd3;

    // Rotation and shift amounts of the XXH64 rounds
    localparam int unsigned ROT_ROUND = 31;
    localparam int unsigned ROT_TAIL8 = 27;
    localparam int unsigned ROT_TAIL4 = 23;
    localparam int unsigned ROT_TAIL1 = 11;
    localparam int unsigned ROT_CONV0 = 1;
    localparam int unsigned ROT_CONV1 = 7;
    localparam int unsigned ROT_CONV2 = 12;
    localparam int unsigned ROT_CONV3 = 18;
    localparam int unsigned AVA_SHIFT0 = 33;
    localparam int unsigned AVA_SHIFT1 = 29;
    localparam int unsigned AVA_SHIFT2 = 32;

    // Steps of the 64x64 (low half) product on a 32x32 multiplier
    localparam logic [1:0] MUL_STEP_LO   = 2'd0;
    localparam logic [1:0] MUL_STEP_HI_A = 2'd1;
    localparam logic [1:0] MUL_STEP_HI_B = 2'd2;

    typedef struct packed {
        logic              start;
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
    } mul_req_t;

    typedef struct packed {
        logic              done;
        logic [WORD_W-1:0] prod;
    } mul_rsp_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_ABSORB,
        ST_RND0,
        ST_RND1,
        ST_RND2,
        ST_FIN_LEN,
        ST_CONV,
        ST_MRG0,
        ST_MRG1,
        ST_MRG2,
        ST_MRG3,
        ST_FIN_ADD,
        ST_TAIL_SEL,
        ST_PND1,
        ST_PND2,
        ST_PND3,
        ST_QRT1,
        ST_QRT2,
        ST_BYTE_SEL,
        ST_BYT1,
        ST_BYT2,
        ST_AVA1,
        ST_AVA2,
        ST_OUT
    } xxh_state_t;

    function automatic logic [WORD_W-1:0] rotl64(input logic [WORD_W-1:0] x,
                                                 input int unsigned r);
        rotl64 = (x << r) | (x >> (WORD_W - r));
    endfunction

endpackage

@@ hw/rtl/xxh64_if.sv @@
// Valid/ready channel interfaces of the XXH64 stream hash core.
// Depends on xxh64_pkg for field widths.

interface xxh64_msg_if;
    logic                               valid;
    logic                               ready;
    logic [xxh64_pkg::WORD_W-1:0]       data_word;
    logic [xxh64_pkg::CNT_W-1:0]        byte_count;
    logic                               last;

    modport source (output valid, data_word, byte_count, last, input ready);
    modport sink   (input valid, data_word, byte_count, last, output ready);
endinterface

interface xxh64_hash_if;
    logic                               valid;
    logic                               ready;
    logic [xxh64_pkg::WORD_W-1:0]       digest;

    modport source (output valid, digest, input ready);
    modport sink   (input valid, digest, output ready);
endinterface

interface xxh64_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [xxh64_pkg::WORD_W-1:0]       seed;

    modport source (output valid, seed, input ready);
    modport sink   (input valid, seed, output ready);
endinterface

@@ hw/rtl/xxh64_mul.sv @@
// Shared 64x64 multiplier (low 64 bits of the product) built on one 32x32 unit.
// Depends on xxh64_pkg for mul_req_t, mul_rsp_t and the step codes.

module xxh64_mul (
    input  logic                clk,
    input  logic                rst_n,
    input  xxh64_pkg::mul_req_t req,
    output xxh64_pkg::mul_rsp_t rsp
);

    logic                         busy_reg;
    logic                         done_reg;
    logic [1:0]                   step_reg;
    logic [xxh64_pkg::WORD_W-1:0] a_reg;
    logic [xxh64_pkg::WORD_W-1:0] b_reg;
    logic [xxh64_pkg::WORD_W-1:0] acc_reg;

    logic [xxh64_pkg::HALF_W-1:0] op_a;
    logic [xxh64_pkg::HALF_W-1:0] op_b;
    logic [xxh64_pkg::WORD_W-1:0] prod;
    logic [xxh64_pkg::WORD_W-1:0] acc_next;

    // Low x low, then both cross terms into the upper half; high x high drops out
    always_comb
    begin
        op_a = (step_reg == xxh64_pkg::MUL_STEP_HI_A) ? a_reg[63:32] : a_reg[31:0];
        op_b = (step_reg == xxh64_pkg::MUL_STEP_HI_B) ? b_reg[63:32] : b_reg[31:0];
        prod = 64'(op_a) * 64'(op_b);
        if (step_reg == xxh64_pkg::MUL_STEP_LO)
        begin
            acc_next = prod;
        end
        else
        begin
            acc_next = acc_reg + {prod[31:0], 32'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= xxh64_pkg::MUL_STEP_LO;
        end
        else
        begin
            done_reg <= busy_reg && (step_reg == xxh64_pkg::MUL_STEP_HI_B);
            if (busy_reg)
            begin
                if (step_reg == xxh64_pkg::MUL_STEP_HI_B)
                begin
                    busy_reg <= 1'b0;
                    step_reg <= xxh64_pkg::MUL_STEP_LO;
                end
                else
                begin
                    step_reg <= step_reg + 2'd1;
                end
            end
            else if (req.start)
            begin
                busy_reg <= 1'b1;
                step_reg <= xxh64_pkg::MUL_STEP_LO;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!busy_reg && req.start)
        begin
            a_reg <= req.a;
            b_reg <= req.b;
        end
        if (busy_reg)
        begin
            acc_reg <= acc_next;
        end
    end

    assign rsp.done = done_reg;
    assign rsp.prod = acc_reg;

endmodule

@@ hw/rtl/xxh64_stream_hash_core.sv @@
// Top level of the XXH64 stream hash core: sequencer, lane and tail state.
// Depends on xxh64_pkg, the channel interfaces in xxh64_if.sv and xxh64_mul.

// Usage:
//   msg  : message beats, 64-bit little-endian words (first byte in bits 7:0).
//          Every beat counts as 8 bytes unless last is set; the last beat carries
//          0 to 8 valid bytes in byte_count (larger values count as 8).
//   hash : one digest beat per message, sent after the last msg beat.
//   cfg  : seed write, always ready; write it only while the core is idle.
// Every 64-bit multiply runs on one shared 32x32 multiplier in three passes,
// and the sequencer waits on it. A word that only fills a stripe slot is parked
// without a multiply; the word that completes a 32-byte stripe runs two
// multiplies per lane. The last word runs the lane merge for a long message
// (3 multiplies per lane), 3 per tail word, 2 for the piece and each byte,
// and 2 for the final avalanche. msg.ready is high only while the sequencer
// is idle.
// Reset clears the message state and sets the seed to zero. The digest sits in
// an output register: a stalled receiver does not block the next message's
// words, only the next digest, which waits in the final state until taken.

module xxh64_stream_hash_core (
    input  logic           clk,
    input  logic           rst_n,
    xxh64_msg_if.sink      msg,
    xxh64_hash_if.source   hash,
    xxh64_cfg_if.sink      cfg
);

    // Control state
    xxh64_pkg::xxh_state_t        state_reg, state_next;
    logic [1:0]                   idx_reg, idx_next;
    logic [2:0]                   pos_reg, pos_next;
    logic [1:0]                   wis_reg, wis_next;
    logic [xxh64_pkg::WORD_W-1:0] len_reg, len_next;
    logic                         long_reg, long_next;
    logic                         out_valid_reg, out_valid_next;
    logic [xxh64_pkg::WORD_W-1:0] seed_reg;

    // Datapath
    logic [xxh64_pkg::WORD_W-1:0] h_reg, h_next;
    logic [xxh64_pkg::WORD_W-1:0] w_reg, w_next;
    logic [xxh64_pkg::CNT_W-1:0]  cnt_reg, cnt_next;
    logic                         last_reg, last_next;
    logic [xxh64_pkg::WORD_W-1:0] digest_reg, digest_next;
    logic [xxh64_pkg::WORD_W-1:0] lane_reg [4];
    logic [xxh64_pkg::WORD_W-1:0] lane_next [4];
    logic [xxh64_pkg::WORD_W-1:0] pend_reg [3];
    logic [xxh64_pkg::WORD_W-1:0] pend_next [3];

    xxh64_pkg::mul_req_t          mul_req;
    xxh64_pkg::mul_rsp_t          mul_rsp;

    logic [xxh64_pkg::WORD_W-1:0] lane_rd;
    logic [xxh64_pkg::WORD_W-1:0] pend_rd;
    logic [xxh64_pkg::WORD_W-1:0] src_word;
    logic [xxh64_pkg::WORD_W-1:0] h_mix;
    logic [xxh64_pkg::WORD_W-1:0] h_av;
    logic [xxh64_pkg::WORD_W-1:0] conv_term;
    logic [7:0]                   tail_byte;

    xxh64_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req),
        .rsp   (mul_rsp)
    );

    // One read address (idx_reg) serves both the lanes and the pending words
    assign lane_rd   = lane_reg[idx_reg];
    assign pend_rd   = pend_reg[idx_reg];
    assign src_word  = (idx_reg == xxh64_pkg::LAST_LANE) ? w_reg : pend_rd;
    assign h_mix     = h_reg ^ mul_rsp.prod;
    assign h_av      = h_reg ^ (h_reg >> xxh64_pkg::AVA_SHIFT0);
    assign tail_byte = w_reg[{pos_reg, 3'b000} +: 8];

    always_comb
    begin
        unique case (idx_reg)
            2'd0:    conv_term = xxh64_pkg::rotl64(lane_rd, xxh64_pkg::ROT_CONV0);
            2'd1:    conv_term = xxh64_pkg::rotl64(lane_rd, xxh64_pkg::ROT_CONV1);
            2'd2:    conv_term = xxh64_pkg::rotl64(lane_rd, xxh64_pkg::ROT_CONV2);
            default: conv_term = xxh64_pkg::rotl64(lane_rd, xxh64_pkg::ROT_CONV3);
        endcase
    end

    assign msg.ready  = (state_reg == xxh64_pkg::ST_IDLE);
    assign cfg.ready  = 1'b1;
    assign hash.valid = out_valid_reg;
    assign hash.digest = digest_reg;

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        pos_next       = pos_reg;
        wis_next       = wis_reg;
        len_next       = len_reg;
        long_next      = long_reg;
        h_next         = h_reg;
        w_next         = w_reg;
        cnt_next       = cnt_reg;
        last_next      = last_reg;
        digest_next    = digest_reg;
        lane_next      = lane_reg;
        pend_next      = pend_reg;
        out_valid_next = out_valid_reg && !hash.ready;
        mul_req.start  = 1'b0;
        mul_req.a      = '0;
        mul_req.b      = '0;

        unique case (state_reg)
            xxh64_pkg::ST_IDLE:
            begin
                if (msg.valid)
                begin
                    w_next    = msg.data_word;
                    cnt_next  = (msg.byte_count > xxh64_pkg::WORD_BYTES) ?
                                xxh64_pkg::WORD_BYTES : msg.byte_count;
                    last_next = msg.last;
                    state_next = xxh64_pkg::ST_ABSORB;
                end
            end

            // Full word: park it in a stripe slot or finish the stripe; a partial last word goes to the finish
            xxh64_pkg::ST_ABSORB:
            begin
                if (!last_reg || (cnt_reg == xxh64_pkg::WORD_BYTES))
                begin
                    len_next = len_reg + xxh64_pkg::WORD_BYTES_64;
                    if (last_reg)
                    begin
                        cnt_next = '0;
                    end
                    if (wis_reg != xxh64_pkg::LAST_LANE)
                    begin
                        // Seed the lanes when a stripe opens on a short message
                        if ((wis_reg == 2'd0) && !long_reg)
                        begin
                            lane_next[0] = seed_reg + xxh64_pkg::PRIME64_1 +
                                           xxh64_pkg::PRIME64_2;
                            lane_next[1] = seed_reg + xxh64_pkg::PRIME64_2;
                            lane_next[2] = seed_reg;
                            lane_next[3] = seed_reg - xxh64_pkg::PRIME64_1;
                        end
                        pend_next[wis_reg] = w_reg;
                        wis_next = wis_reg + 2'd1;
                        state_next = last_reg ? xxh64_pkg::ST_FIN_LEN : xxh64_pkg::ST_IDLE;
                    end
                    else
                    begin
                        idx_next   = '0;
                        state_next = xxh64_pkg::ST_RND0;
                    end
                end
                else
                begin
                    state_next = xxh64_pkg::ST_FIN_LEN;
                end
            end

            // Lane round: acc = rotl(acc + w * P2, 31) * P1
            xxh64_pkg::ST_RND0:
            begin
                mul_req.start = 1'b1;
                mul_req.a     = src_word;
                mul_req.b     = xxh64_pkg::PRIME64_2;
                state_next    = xxh64_pkg::ST_RND1;
            end

            xxh64_pkg::ST_RND1:
            begin
                if (mul_rsp.done)
                begin
                    mul_req.start = 1'b1;
                    mul_req.a     = xxh64_pkg::rotl64(lane_rd + mul_rsp.prod,
                                                      xxh64_pkg::ROT_ROUND);
                    mul_req.b     = xxh64_pkg::PRIME64_1;
                    state_next    = xxh64_pkg::ST_RND2;
                end
            end

            xxh64_pkg::ST_RND2:
            begin
                if (mul_rsp.done)
                begin
                    lane_next[idx_reg] = mul_rsp.prod;
                    if (idx_reg == xxh64_pkg::LAST_LANE)
                    begin
                        idx_next   = '0;
                        wis_next   = '0;
                        long_next  = 1'b1;
                        state_next = last_reg ? xxh64_pkg::ST_FIN_LEN : xxh64_pkg::ST_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 2'd1;
                        state_next = xxh64_pkg::ST_RND0;
                    end
                end
            end

            xxh64_pkg::ST_FIN_LEN:
            begin
                len_next = len_reg + {{(xxh64_pkg::WORD_W - xxh64_pkg::CNT_W){1'b0}}, cnt_reg};
                idx_next = '0;
                if (long_reg)
                begin
                    h_next     = '0;
                    state_next = xxh64_pkg::ST_CONV;
                end
                else
                begin
                    h_next     = seed_reg + xxh64_pkg::PRIME64_5;
                    state_next = xxh64_pkg::ST_FIN_ADD;
                end
            end

            // Converge the lanes, one rotated lane per cycle
            xxh64_pkg::ST_CONV:
            begin
                h_next = h_reg + conv_term;
                if (idx_reg == xxh64_pkg::LAST_LANE)
                begin
                    idx_next   = '0;
                    state_next = xxh64_pkg::ST_MRG0;
                end
                else
                begin
                    idx_next = idx_reg + 2'd1;
                end
            end

            // Merge: h ^= round(0, lane); h = h * P1 + P4
            xxh64_pkg::ST_MRG0:
            begin
                mul_req.start = 1'b1;
                mul_req.a     = lane_rd;
                mul_req.b     = xxh64_pkg::PRIME64_2;
                state_next    = xxh64_pkg::ST_MRG1;
            end

            xxh64_pkg::ST_MRG1:
            begin
                if (mul_rsp.done)
                begin
                    mul_req.start = 1'b1;
                    mul_req.a     = xxh64_pkg::rotl64(mul_rsp.prod, xxh64_pkg::ROT_ROUND);
                    mul_req.b     = xxh64_pkg::PRIME64_1;
                    state_next    = xxh64_pkg::ST_MRG2;
                end
            end

            xxh64_pkg::ST_MRG2:
            begin
                if (mul_rsp.done)
                begin
                    h_next        = h_mix;
                    mul_req.start = 1'b1;
                    mul_req.a     = h_mix;
                    mul_req.b     = xxh64_pkg::PRIME64_1;
                    state_next    = xxh64_pkg::ST_MRG3;
                end
            end

            xxh64_pkg::ST_MRG3:
            begin
                if (mul_rsp.done)
                begin
                    h_next = mul_rsp.prod + xxh64_pkg::PRIME64_4;
                    if (idx_reg == xxh64_pkg::LAST_LANE)
                    begin
                        idx_next   = '0;
                        state_next = xxh64_pkg::ST_FIN_ADD;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 2'd1;
                        state_next = xxh64_pkg::ST_MRG0;
                    end
                end
            end

            xxh64_pkg::ST_FIN_ADD:
            begin
                h_next     = h_reg + len_reg;
                idx_next   = '0;
                state_next = xxh64_pkg::ST_TAIL_SEL;
            end

            // Walk the tail: pending words first, then the 4-byte piece
            xxh64_pkg::ST_TAIL_SEL:
            begin
                priority if (idx_reg < wis_reg)
                begin
                    mul_req.start = 1'b1;
                    mul_req.a     = pend_rd;
                    mul_req.b     = xxh64_pkg::PRIME64_2;
                    state_next    = xxh64_pkg::ST_PND1;
                end
                else if (cnt_reg >= xxh64_pkg::HALF_WORD_BYTES)
                begin
                    mul_req.start = 1'b1;
                    mul_req.a     = {32'b0, w_reg[31:0]};
                    mul_req.b     = xxh64_pkg::PRIME64_1;
                    pos_next      = xxh64_pkg::POS_AFTER_HALF;
                    state_next    = xxh64_pkg::ST_QRT1;
                end
                else
                begin
                    pos_next   = '0;
                    state_next = xxh64_pkg::ST_BYTE_SEL;
                end
            end

            xxh64_pkg::ST_PND1:
            begin
                if (mul_rsp.done)
                begin
                    mul_req.start = 1'b1;
                    mul_req.a     = xxh64_pkg::rotl64(mul_rsp.prod, xxh64_pkg::ROT_ROUND);
                    mul_req.b     = xxh64_pkg::PRIME64_1;
                    state_next    = xxh64_pkg::ST_PND2;
                end
            end

            xxh64_pkg::ST_PND2:
            begin
                if (mul_rsp.done)
                begin
                    h_next        = h_mix;
                    mul_req.start = 1'b1;
                    mul_req.a     = xxh64_pkg::rotl64(h_mix, xxh64_pkg::ROT_TAIL8);
                    mul_req.b     = xxh64_pkg::PRIME64_1;
                    state_next    = xxh64_pkg::ST_PND3;
                end
            end

            xxh64_pkg::ST_PND3:
            begin
                if (mul_rsp.done)
                begin
                    h_next     = mul_rsp.prod + xxh64_pkg::PRIME64_4;
                    idx_next   = idx_reg + 2'd1;
                    state_next = xxh64_pkg::ST_TAIL_SEL;
                end
            end

            xxh64_pkg::ST_QRT1:
            begin
                if (mul_rsp.done)
                begin
                    h_next        = h_mix;
                    mul_req.start = 1'b1;
                    mul_req.a     = xxh64_pkg::rotl64(h_mix, xxh64_pkg::ROT_TAIL4);
                    mul_req.b     = xxh64_pkg::PRIME64_2;
                    state_next    = xxh64_pkg::ST_QRT2;
                end
            end

            xxh64_pkg::ST_QRT2:
            begin
                if (mul_rsp.done)
                begin
                    h_next     = mul_rsp.prod + xxh64_pkg::PRIME64_3;
                    state_next = xxh64_pkg::ST_BYTE_SEL;
                end
            end

            // Single bytes, then open the avalanche
            xxh64_pkg::ST_BYTE_SEL:
            begin
                if ({1'b0, pos_reg} < cnt_reg)
                begin
                    mul_req.start = 1'b1;
                    mul_req.a     = {56'b0, tail_byte};
                    mul_req.b     = xxh64_pkg::PRIME64_5;
                    state_next    = xxh64_pkg::ST_BYT1;
                end
                else
                begin
                    h_next        = h_av;
                    mul_req.start = 1'b1;
                    mul_req.a     = h_av;
                    mul_req.b     = xxh64_pkg::PRIME64_2;
                    state_next    = xxh64_pkg::ST_AVA1;
                end
            end

            xxh64_pkg::ST_BYT1:
            begin
                if (mul_rsp.done)
                begin
                    h_next        = h_mix;
                    mul_req.start = 1'b1;
                    mul_req.a     = xxh64_pkg::rotl64(h_mix, xxh64_pkg::ROT_TAIL1);
                    mul_req.b     = xxh64_pkg::PRIME64_1;
                    state_next    = xxh64_pkg::ST_BYT2;
                end
            end

            xxh64_pkg::ST_BYT2:
            begin
                if (mul_rsp.done)
                begin
                    h_next     = mul_rsp.prod;
                    pos_next   = pos_reg + 3'd1;
                    state_next = xxh64_pkg::ST_BYTE_SEL;
                end
            end

            xxh64_pkg::ST_AVA1:
            begin
                if (mul_rsp.done)
                begin
                    mul_req.start = 1'b1;
                    mul_req.a     = mul_rsp.prod ^ (mul_rsp.prod >> xxh64_pkg::AVA_SHIFT1);
                    mul_req.b     = xxh64_pkg::PRIME64_3;
                    state_next    = xxh64_pkg::ST_AVA2;
                end
            end

            xxh64_pkg::ST_AVA2:
            begin
                if (mul_rsp.done)
                begin
                    h_next     = mul_rsp.prod ^ (mul_rsp.prod >> xxh64_pkg::AVA_SHIFT2);
                    state_next = xxh64_pkg::ST_OUT;
                end
            end

            // Hold the digest until the output register frees up
            xxh64_pkg::ST_OUT:
            begin
                if (!out_valid_reg || hash.ready)
                begin
                    digest_next    = h_reg;
                    out_valid_next = 1'b1;
                    wis_next       = '0;
                    len_next       = '0;
                    long_next      = 1'b0;
                    idx_next       = '0;
                    state_next     = xxh64_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = xxh64_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= xxh64_pkg::ST_IDLE;
            idx_reg       <= '0;
            pos_reg       <= '0;
            wis_reg       <= '0;
            len_reg       <= '0;
            long_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            seed_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            pos_reg       <= pos_next;
            wis_reg       <= wis_next;
            len_reg       <= len_next;
            long_reg      <= long_next;
            out_valid_reg <= out_valid_next;
            if (cfg.valid)
            begin
                seed_reg <= cfg.seed;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        h_reg      <= h_next;
        w_reg      <= w_next;
        cnt_reg    <= cnt_next;
        last_reg   <= last_next;
        digest_reg <= digest_next;
        lane_reg   <= lane_next;
        pend_reg   <= pend_next;
    end

endmodule

@@ test/xxh64_stream_hash_core_test.sv @@
`timescale 1ns / 1ps
// Self-checking bench for xxh64_stream_hash_core: a directed message table, then random
// messages in four flow-control phases, digests checked vs. table or in-bench XXH64 model.
// Depends on xxh64_pkg and the channel interfaces in xxh64_if.sv.

module xxh64_stream_hash_core_test;

    typedef logic [xxh64_pkg::WORD_W-1:0] word_t;

    // Row kinds of the directed table: a message beat, or a seed write between beats
    typedef enum logic {ROW_BEAT, ROW_SEED} row_kind_t;

    typedef struct packed {
        row_kind_t                    kind;
        word_t                        word;   // beat data, or the seed for a ROW_SEED row
        logic [xxh64_pkg::CNT_W-1:0]  cnt;
        logic                         last;
        logic                         typed;  // digest given in the table, not predicted
        word_t                        want;
    } script_row_t;

    // Covers the longest stretch the core can stay busy on one beat (last beat of a long message)
    localparam int unsigned SETTLE_CYCLES = 200;
    localparam int unsigned CYCLE_LIMIT   = 1500000;
    localparam int unsigned PHASE_BEATS   = 450;
    localparam int unsigned HOLD_CYCLES   = 500;

    // Flow-control phases: free running, sender gaps, receiver stalls, both
    localparam int unsigned GAP_PCT   [4] = '{0, 46, 0, 30};
    localparam int unsigned STALL_PCT [4] = '{0, 0, 46, 30};

    logic clk;
    logic rst_n;

    xxh64_msg_if  msg_ch ();
    xxh64_hash_if hash_ch ();
    xxh64_cfg_if  cfg_ch ();

    xxh64_stream_hash_core dut (
        .clk   (clk),
        .rst_n (rst_n),
        .msg   (msg_ch),
        .hash  (hash_ch),
        .cfg   (cfg_ch)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    // ------------------------------------------------------------------
    // Hash model state: lanes, words waiting for their stripe, length
    // ------------------------------------------------------------------
    word_t            seed_now;
    word_t            lane [4];
    word_t            held [3];
    logic [1:0]       held_n;
    word_t            byte_total;
    bit               striped;

    word_t            digest_due [$];   // digests owed by the core, oldest first
    script_row_t      script [$];

    bit               failed;
    word_t            want_digest;
    int unsigned      beats_sent;
    int unsigned      cycle_count;
    int unsigned      gap_pct;
    int unsigned      stall_pct;
    int unsigned      hold_request;
    int unsigned      hold_left;

    function automatic word_t rol(word_t x, int unsigned r);
        return (x << r) | (x >> (xxh64_pkg::WORD_W - r));
    endfunction

    // One XXH64 lane round: add the scaled word, rotate, scale
    function automatic word_t mix_round(word_t acc, word_t w);
        acc = acc + w * xxh64_pkg::PRIME64_2;
        acc = rol(acc, 31);
        return acc * xxh64_pkg::PRIME64_1;
    endfunction

    task automatic seed_lanes();
        lane[0] = seed_now + xxh64_pkg::PRIME64_1 + xxh64_pkg::PRIME64_2;
        lane[1] = seed_now + xxh64_pkg::PRIME64_2;
        lane[2] = seed_now;
        lane[3] = seed_now - xxh64_pkg::PRIME64_1;
    endtask

    task automatic restart_message();
        seed_lanes();
        held_n     = 2'd0;
        byte_total = '0;
        striped    = 1'b0;
    endtask

    // Park a full word; the fourth word of a stripe runs all four lanes.
    // Lanes pick up the seed only when the first stripe of a message begins.
    task automatic take_word(input word_t w);
        byte_total = byte_total + 64'd8;
        if (held_n != 2'd3)
        begin
            if (held_n == 2'd0 && !striped)
                seed_lanes();
            held[held_n] = w;
            held_n       = held_n + 2'd1;
        end
        else
        begin
            lane[0] = mix_round(lane[0], held[0]);
            lane[1] = mix_round(lane[1], held[1]);
            lane[2] = mix_round(lane[2], held[2]);
            lane[3] = mix_round(lane[3], w);
            held_n  = 2'd0;
            striped = 1'b1;
        end
    endtask

    // Fold the last beat and the tail into the digest, then reopen for a new message
    task automatic close_message(input word_t w,
                                 input logic [xxh64_pkg::CNT_W-1:0] cnt_in,
                                 output word_t h);
        int unsigned n;
        int unsigned pos;
        int          i;
        n = (cnt_in > 4'd8) ? 8 : cnt_in;
        if (n == 8)
        begin
            take_word(w);
            n = 0;
        end
        byte_total = byte_total + word_t'(n);

        if (striped)
        begin
            h = rol(lane[0], 1) + rol(lane[1], 7) + rol(lane[2], 12) + rol(lane[3], 18);
            for (i = 0; i < 4; i++)
            begin
                h = h ^ mix_round('0, lane[i]);
                h = h * xxh64_pkg::PRIME64_1 + xxh64_pkg::PRIME64_4;
            end
        end
        else
            h = seed_now + xxh64_pkg::PRIME64_5;
        h = h + byte_total;

        for (i = 0; i < held_n; i++)
        begin
            h = h ^ mix_round('0, held[i]);
            h = rol(h, 27) * xxh64_pkg::PRIME64_1 + xxh64_pkg::PRIME64_4;
        end
        pos = 0;
        if (n >= 4)
        begin
            h   = h ^ ({32'd0, w[31:0]} * xxh64_pkg::PRIME64_1);
            h   = rol(h, 23) * xxh64_pkg::PRIME64_2 + xxh64_pkg::PRIME64_3;
            pos = 4;
        end
        for (; pos < n; pos++)
        begin
            h = h ^ ({56'd0, w[8*pos +: 8]} * xxh64_pkg::PRIME64_5);
            h = rol(h, 11) * xxh64_pkg::PRIME64_1;
        end

        // Final avalanche
        h = h ^ (h >> 33);
        h = h * xxh64_pkg::PRIME64_2;
        h = h ^ (h >> 29);
        h = h * xxh64_pkg::PRIME64_3;
        h = h ^ (h >> 32);
        restart_message();
    endtask

    function automatic word_t rand_word();
        return {$urandom, $urandom};
    endfunction

    function automatic script_row_t mk_row(row_kind_t k, word_t w,
                                           logic [xxh64_pkg::CNT_W-1:0] c,
                                           logic l, logic t, word_t d);
        script_row_t r;
        r.kind  = k;
        r.word  = w;
        r.cnt   = c;
        r.last  = l;
        r.typed = t;
        r.want  = d;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Message side: offer one beat, with random gaps ahead of it.
    // Valid stays high after the beat is taken so back-to-back beats
    // never drop and raise valid in one step; callers that stop sending
    // go through wait_idle, which drops it.
    // ------------------------------------------------------------------
    task automatic put_word(input word_t w, input logic [xxh64_pkg::CNT_W-1:0] cnt,
                            input logic last, input logic typed, input word_t want);
        word_t d;
        while ($urandom_range(99) < gap_pct)
        begin
            msg_ch.valid <= 1'b0;
            @(posedge clk);
        end
        msg_ch.valid      <= 1'b1;
        msg_ch.data_word  <= w;
        msg_ch.byte_count <= cnt;
        msg_ch.last       <= last;
        @(posedge clk);
        while (!msg_ch.ready)
            @(posedge clk);
        beats_sent++;
        if (last)
        begin
            close_message(w, cnt, d);
            digest_due.push_back(typed ? want : d);
        end
        else
            take_word(w);
    endtask

    // Drop valid and hold until every owed digest has come back
    task automatic wait_idle();
        msg_ch.valid <= 1'b0;
        while (digest_due.size() != 0)
            @(posedge clk);
    endtask

    // Seed writes happen only with the core idle: drain, then let a beat that
    // owes no digest finish before touching the register.
    task automatic write_seed(input word_t v);
        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.seed  <= v;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        seed_now      = v;
        cfg_ch.valid <= 1'b0;
    endtask

    // Mostly short messages, some spanning several stripes, a few long ones.
    // Non-last beats sometimes carry a junk byte count, which the core ignores.
    task automatic send_random_message();
        int unsigned                  len;
        int unsigned                  pick;
        int unsigned                  k;
        logic [xxh64_pkg::CNT_W-1:0]  c;
        pick = $urandom_range(99);
        if (pick < 70)
            len = $urandom_range(0, 7);
        else if (pick < 92)
            len = $urandom_range(8, 20);
        else
            len = $urandom_range(21, 40);
        for (k = 0; k < len; k++)
        begin
            c = ($urandom_range(3) == 0) ? 4'($urandom_range(15)) : xxh64_pkg::WORD_BYTES;
            put_word(rand_word(), c, 1'b0, 1'b0, '0);
        end
        c = ($urandom_range(4) == 0) ? 4'($urandom_range(9, 15)) : 4'($urandom_range(0, 8));
        put_word(rand_word(), c, 1'b1, 1'b0, '0);
    endtask

    // ------------------------------------------------------------------
    // Digest side: ready with random stalls, or held low for a counted
    // stretch on request so the core backs up into the message channel.
    // ------------------------------------------------------------------
    initial
    begin
        hash_ch.ready = 1'b0;
        hold_left     = 0;
        forever
        begin
            @(posedge clk);
            if (hold_request != 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left != 0)
            begin
                hash_ch.ready <= 1'b0;
                hold_left--;
            end
            else
                hash_ch.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Check each digest beat against the oldest owed digest
    always @(posedge clk)
    begin
        if (rst_n && hash_ch.valid && hash_ch.ready)
        begin
            if (digest_due.size() == 0)
            begin
                $display("%0t: unexpected digest beat: expected none, got %h",
                         $time, hash_ch.digest);
                failed = 1'b1;
            end
            else
            begin
                want_digest = digest_due.pop_front();
                if (hash_ch.digest !== want_digest)
                begin
                    $display("%0t: digest mismatch: expected %h, got %h",
                             $time, want_digest, hash_ch.digest);
                    failed = 1'b1;
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin : main_seq
        int unsigned ph;
        int unsigned start;
        int unsigned k;
        bit          pressed;
        word_t       phase_seed;

        failed         = 1'b0;
        beats_sent     = 0;
        cycle_count    = 0;
        gap_pct        = 0;
        stall_pct      = 0;
        hold_request   = 0;
        pressed        = 1'b0;
        seed_now       = '0;
        restart_message();

        rst_n             = 1'b0;
        msg_ch.valid      = 1'b0;
        msg_ch.data_word  = '0;
        msg_ch.byte_count = '0;
        msg_ch.last       = 1'b0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.seed       = '0;

        // Known digests with seed zero: the empty message and "abc"
        script.push_back(mk_row(ROW_BEAT, 64'h0, 4'd0, 1'b1, 1'b1, 64'hEF46DB3751D8E999));
        script.push_back(mk_row(ROW_BEAT, 64'h0000000000636261, 4'd3, 1'b1, 1'b1,
                                64'h44BC2CF5AD770999));
        // All-ones seed; one-beat messages: full, oversized count, 4-byte piece, piece+bytes
        script.push_back(mk_row(ROW_SEED, 64'hFFFFFFFFFFFFFFFF, 4'd0, 1'b0, 1'b0, '0));
        script.push_back(mk_row(ROW_BEAT, 64'hFFFFFFFFFFFFFFFF, 4'd8, 1'b1, 1'b0, '0));
        script.push_back(mk_row(ROW_BEAT, 64'hFFFFFFFFFFFFFFFF, 4'd15, 1'b1, 1'b0, '0));
        script.push_back(mk_row(ROW_BEAT, 64'h0123456789ABCDEF, 4'd4, 1'b1, 1'b0, '0));
        script.push_back(mk_row(ROW_BEAT, 64'hFEDCBA9876543210, 4'd7, 1'b1, 1'b0, '0));
        // One full stripe with junk counts on three of its beats, then a partial tail
        script.push_back(mk_row(ROW_BEAT, 64'hFFFFFFFFFFFFFFFF, 4'd0, 1'b0, 1'b0, '0));
        script.push_back(mk_row(ROW_BEAT, 64'h0000000000000000, 4'd15, 1'b0, 1'b0, '0));
        script.push_back(mk_row(ROW_BEAT, 64'hAAAAAAAAAAAAAAAA, 4'd8, 1'b0, 1'b0, '0));
        script.push_back(mk_row(ROW_BEAT, 64'h5555555555555555, 4'd1, 1'b0, 1'b0, '0));
        script.push_back(mk_row(ROW_BEAT, 64'h0F0F0F0F0F0F0F0F, 4'd5, 1'b1, 1'b0, '0));
        // Seed change after the first beat of a long message: lanes keep the old seed
        script.push_back(mk_row(ROW_BEAT, 64'h1111111111111111, 4'd8, 1'b0, 1'b0, '0));
        script.push_back(mk_row(ROW_SEED, 64'h8000000000000001, 4'd0, 1'b0, 1'b0, '0));
        script.push_back(mk_row(ROW_BEAT, 64'h2222222222222222, 4'd8, 1'b0, 1'b0, '0));
        script.push_back(mk_row(ROW_BEAT, 64'h3333333333333333, 4'd8, 1'b0, 1'b0, '0));
        script.push_back(mk_row(ROW_BEAT, 64'h4444444444444444, 4'd8, 1'b0, 1'b0, '0));
        script.push_back(mk_row(ROW_BEAT, 64'h5A5A5A5A5A5A5A5A, 4'd2, 1'b1, 1'b0, '0));
        // Seed change inside a short message: its last beat sees the new seed
        script.push_back(mk_row(ROW_BEAT, 64'h7777777777777777, 4'd8, 1'b0, 1'b0, '0));
        script.push_back(mk_row(ROW_SEED, 64'h0, 4'd0, 1'b0, 1'b0, '0));
        script.push_back(mk_row(ROW_BEAT, 64'h9999999999999999, 4'd6, 1'b1, 1'b0, '0));
        // Three parked words, then a full last beat that completes the stripe
        script.push_back(mk_row(ROW_BEAT, 64'hC3C3C3C3C3C3C3C3, 4'd8, 1'b0, 1'b0, '0));
        script.push_back(mk_row(ROW_BEAT, 64'h3C3C3C3C3C3C3C3C, 4'd8, 1'b0, 1'b0, '0));
        script.push_back(mk_row(ROW_BEAT, 64'h0000000000000000, 4'd8, 1'b0, 1'b0, '0));
        script.push_back(mk_row(ROW_BEAT, 64'hFFFFFFFFFFFFFFFF, 4'd8, 1'b1, 1'b0, '0));

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed table
        for (k = 0; k < script.size(); k++)
        begin
            if (script[k].kind == ROW_SEED)
                write_seed(script[k].word);
            else
                put_word(script[k].word, script[k].cnt, script[k].last,
                         script[k].typed, script[k].want);
        end

        // Random messages across the flow-control phases, a new seed for each
        for (ph = 0; ph < 4; ph++)
        begin
            case (ph)
                1:       phase_seed = 64'hFFFFFFFFFFFFFFFF;
                2:       phase_seed = 64'h0;
                default: phase_seed = rand_word();
            endcase
            write_seed(phase_seed);
            gap_pct   = GAP_PCT[ph];
            stall_pct = STALL_PCT[ph];
            start     = beats_sent;
            while (beats_sent - start < PHASE_BEATS)
            begin
                // Once: hold the digest side off while short messages keep coming,
                // so the output register and sequencer fill and msg.ready drops;
                // then pause the sender until every digest is back.
                if (ph == 0 && !pressed && beats_sent - start >= PHASE_BEATS / 2)
                begin
                    wait_idle();
                    hold_request = HOLD_CYCLES;
                    repeat (6)
                        put_word(rand_word(), 4'($urandom_range(0, 8)), 1'b1, 1'b0, '0);
                    wait_idle();
                    pressed = 1'b1;
                end
                send_random_message();
            end
        end

        // Drain, give the core time to misbehave, then judge
        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (failed || digest_due.size() != 0)
            $display("Some tests failed");
        else
            $display("All tests passed");
        $finish;
    end

endmodule
